FILE: src/plie_pkg.sv
// ----------------------------------------------------------------------------
// plie_pkg
// Shared widths, defaults, lane control and a CRC helper for the PCM line
// interleave encoder.
// ----------------------------------------------------------------------------
package plie_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int WORD_W      = 14;
  localparam int CRC_W       = 16;
  localparam int N_SAMPLES   = 6;
  localparam int N_CRC_WORDS = 7;
  localparam int N_LANES     = 8;
  localparam int MSG_BITS    = N_CRC_WORDS * WORD_W;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  localparam int HISTORY_DEPTH_DEF = 128;
  localparam int DELAY_STEP_DEF    = 16;

  typedef struct packed {
    logic accept;
    logic load2;
  } lane_ctl_t;

  // CRC of a message that holds a single one at bit position pos (MSB first)
  function automatic logic [CRC_W-1:0] crc_column(int unsigned pos);
    logic [CRC_W-1:0] crc;
    int unsigned      i;
    crc = CRC_POLY;
    for (i = pos + 1; i < MSG_BITS; i++) begin
      if (crc[CRC_W-1]) begin
        crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[CRC_W-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

FILE: src/plie_lane.sv
// ----------------------------------------------------------------------------
// plie_lane
// One interleave lane: line delay store, zero fill until written, and the
// lane's share of the line CRC.
// ----------------------------------------------------------------------------
module plie_lane #(
  parameter int HISTORY_DEPTH = plie_pkg::HISTORY_DEPTH_DEF,
  parameter int DELAY         = 0,
  parameter bit HAS_CRC       = 1'b1,
  parameter int CRC_SLOT      = 0,
  localparam int IDX_W        = $clog2(HISTORY_DEPTH),
  localparam int CNT_W        = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic                          clk,
  input  plie_pkg::lane_ctl_t           ctl,
  input  logic [IDX_W-1:0]              line_index,
  input  logic [CNT_W-1:0]              fill_count,
  input  logic [plie_pkg::WORD_W-1:0]   word_in,
  output logic [plie_pkg::WORD_W-1:0]   word_out,
  output logic [plie_pkg::CRC_W-1:0]    crc_part
);

  localparam int DLY = DELAY % HISTORY_DEPTH;

  logic                        hit1;
  logic [plie_pkg::WORD_W-1:0] word_sel;
  logic [plie_pkg::CRC_W-1:0]  crc_sel;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      hit1 <= (fill_count >= CNT_W'(DLY));
    end
  end

  if (DLY == 0) begin : g_bypass
    logic [plie_pkg::WORD_W-1:0] word1;

    always_ff @(posedge clk) begin
      if (ctl.accept) begin
        word1 <= word_in;
      end
    end

    assign word_sel = hit1 ? word1 : '0;
  end else begin : g_store
    localparam logic [IDX_W:0] DLY_V   = (IDX_W + 1)'(DLY);
    localparam logic [IDX_W:0] DEPTH_V = (IDX_W + 1)'(HISTORY_DEPTH);

    logic [plie_pkg::WORD_W-1:0] mem [HISTORY_DEPTH];
    logic [plie_pkg::WORD_W-1:0] rdata;
    logic [IDX_W:0]              raddr_wide;
    logic [IDX_W-1:0]            raddr;

    always_comb begin
      if ({1'b0, line_index} >= DLY_V) begin
        raddr_wide = {1'b0, line_index} - DLY_V;
      end else begin
        raddr_wide = {1'b0, line_index} + DEPTH_V - DLY_V;
      end
      raddr = raddr_wide[IDX_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (ctl.accept) begin
        mem[line_index] <= word_in;
        rdata           <= mem[raddr];
      end
    end

    assign word_sel = hit1 ? rdata : '0;
  end

  if (HAS_CRC) begin : g_crc
    logic [plie_pkg::CRC_W-1:0] terms [plie_pkg::WORD_W];

    for (genvar b = 0; b < plie_pkg::WORD_W; b++) begin : g_bit
      localparam logic [plie_pkg::CRC_W-1:0] COL =
        plie_pkg::crc_column(plie_pkg::WORD_W * CRC_SLOT + plie_pkg::WORD_W - 1 - b);
      assign terms[b] = word_sel[b] ? COL : '0;
    end

    always_comb begin
      crc_sel = '0;
      for (int i = 0; i < plie_pkg::WORD_W; i++) begin
        crc_sel = crc_sel ^ terms[i];
      end
    end
  end else begin : g_no_crc
    assign crc_sel = '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.load2) begin
      word_out <= word_sel;
      crc_part <= crc_sel;
    end
  end

endmodule

FILE: src/plie_merge.sv
// ----------------------------------------------------------------------------
// plie_merge
// Combine lane CRC shares into the check word and hold the line result in
// the output register.
// ----------------------------------------------------------------------------
module plie_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [plie_pkg::WORD_W-1:0] words [plie_pkg::N_LANES],
  input  logic [plie_pkg::CRC_W-1:0]  parts [plie_pkg::N_LANES],
  output logic                        line_valid,
  input  logic                        line_stall,
  output logic [plie_pkg::WORD_W-1:0] words_out [plie_pkg::N_LANES],
  output logic [plie_pkg::CRC_W-1:0]  check_word
);

  logic [plie_pkg::CRC_W-1:0] crc_all;

  always_comb begin
    crc_all = '0;
    for (int i = 0; i < plie_pkg::N_LANES; i++) begin
      crc_all = crc_all ^ parts[i];
    end
  end

  assign in_ready = !line_valid || !line_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= 1'b0;
    end else if (in_ready) begin
      line_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      words_out  <= words;
      check_word <= crc_all;
    end
  end

endmodule

FILE: src/pcm_line_interleave_encoder.sv
// A sample transfer passes the lane read, lane output and merge output registers.
// Throughput: one line per cycle while line_stall is low; each lane store takes one
// write and one read per cycle, and the three pipeline stages collapse bubbles on stall.
// Reset clears line index, fill count and stage valids; no clearing pass:
// entries not yet written read as zero through the fill count.
// ----------------------------------------------------------------------------
// pcm_line_interleave_encoder
// Splits six samples into words, parity and low-bit word, delays each in its
// own lane store and merges the lanes into one line result with CRC-16.
// ----------------------------------------------------------------------------
module pcm_line_interleave_encoder #(
  parameter int HISTORY_DEPTH = plie_pkg::HISTORY_DEPTH_DEF,
  parameter int DELAY_STEP    = plie_pkg::DELAY_STEP_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [plie_pkg::SAMPLE_W-1:0] sample_0,
  input  logic signed [plie_pkg::SAMPLE_W-1:0] sample_1,
  input  logic signed [plie_pkg::SAMPLE_W-1:0] sample_2,
  input  logic signed [plie_pkg::SAMPLE_W-1:0] sample_3,
  input  logic signed [plie_pkg::SAMPLE_W-1:0] sample_4,
  input  logic signed [plie_pkg::SAMPLE_W-1:0] sample_5,
  output logic                                line_valid,
  input  logic                                line_stall,
  output logic [plie_pkg::WORD_W-1:0]         word_1,
  output logic [plie_pkg::WORD_W-1:0]         word_2,
  output logic [plie_pkg::WORD_W-1:0]         word_3,
  output logic [plie_pkg::WORD_W-1:0]         word_4,
  output logic [plie_pkg::WORD_W-1:0]         word_5,
  output logic [plie_pkg::WORD_W-1:0]         word_6,
  output logic [plie_pkg::WORD_W-1:0]         parity_word,
  output logic [plie_pkg::CRC_W-1:0]          check_word,
  output logic [plie_pkg::WORD_W-1:0]         low_bits_word
);

  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(HISTORY_DEPTH);

  logic [IDX_W-1:0] line_index;
  logic [CNT_W-1:0] fill_count;
  logic             v1;
  logic             v2;
  logic             ready1;
  logic             ready2;
  logic             merge_ready;
  logic             accept;

  plie_pkg::lane_ctl_t ctl;

  logic [plie_pkg::SAMPLE_W-1:0] samples   [plie_pkg::N_SAMPLES];
  logic [plie_pkg::WORD_W-1:0]   lane_in   [plie_pkg::N_LANES];
  logic [plie_pkg::WORD_W-1:0]   lane_word [plie_pkg::N_LANES];
  logic [plie_pkg::CRC_W-1:0]    lane_crc  [plie_pkg::N_LANES];
  logic [plie_pkg::WORD_W-1:0]   out_words [plie_pkg::N_LANES];

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;
  assign samples[4] = sample_4;
  assign samples[5] = sample_5;

  always_comb begin
    logic [plie_pkg::WORD_W-1:0] par;
    logic [plie_pkg::WORD_W-1:0] q;
    par = '0;
    q   = '0;
    for (int i = 0; i < plie_pkg::N_SAMPLES; i++) begin
      lane_in[i] = samples[i][plie_pkg::SAMPLE_W-1:2];
      par        = par ^ samples[i][plie_pkg::SAMPLE_W-1:2];
      q[plie_pkg::WORD_W-1-2*i -: 2] = samples[i][1:0];
    end
    lane_in[plie_pkg::N_SAMPLES]     = par;
    lane_in[plie_pkg::N_SAMPLES + 1] = q;
  end

  assign ready2       = !v2 || merge_ready;
  assign ready1       = !v1 || ready2;
  assign sample_stall = !ready1;
  assign accept       = sample_valid && ready1;
  assign ctl.accept   = accept;
  assign ctl.load2    = v1 && ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_index <= '0;
      fill_count <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= sample_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (accept) begin
        line_index <= (line_index == LAST_INDEX) ? '0 : line_index + 1'b1;
        if (fill_count != FULL_COUNT) begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  for (genvar k = 0; k < plie_pkg::N_LANES; k++) begin : g_lane
    plie_lane #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .DELAY        (k * DELAY_STEP),
      .HAS_CRC      (k < plie_pkg::N_CRC_WORDS),
      .CRC_SLOT     (k)
    ) u_lane (
      .clk       (clk),
      .ctl       (ctl),
      .line_index(line_index),
      .fill_count(fill_count),
      .word_in   (lane_in[k]),
      .word_out  (lane_word[k]),
      .crc_part  (lane_crc[k])
    );
  end

  plie_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (merge_ready),
    .words     (lane_word),
    .parts     (lane_crc),
    .line_valid(line_valid),
    .line_stall(line_stall),
    .words_out (out_words),
    .check_word(check_word)
  );

  assign word_1        = out_words[0];
  assign word_2        = out_words[1];
  assign word_3        = out_words[2];
  assign word_4        = out_words[3];
  assign word_5        = out_words[4];
  assign word_6        = out_words[5];
  assign parity_word   = out_words[6];
  assign low_bits_word = out_words[7];

`ifndef SYNTHESIS
  a_hold_stage1: assert property (@(posedge clk) disable iff (rst)
    (v1 && !ready2) |-> sample_stall)
    else $error("transfer taken while stage 1 is blocked");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL_COUNT)
    else $error("fill count passed the store depth");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (accept && line_index != LAST_INDEX) |=> line_index == $past(line_index) + 1'b1)
    else $error("line index did not advance");

  a_index_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && line_index == LAST_INDEX) |=> line_index == '0)
    else $error("line index did not wrap");

  a_stage1_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("transfer lost before stage 1");
`endif

endmodule

FILE: test/pcm_line_interleave_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_line_interleave_encoder_tb
// Drives six-sample lines into the encoder with random gaps and random result
// backpressure. A scoreboard keeps its own interleave delay stores and CRC,
// predicts every line result and compares each result field against it.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [5:0][13:0] words;
  logic [13:0]      parity;
  logic [15:0]      crc;
  logic [13:0]      low_bits;
} line_result_t;

class line_scoreboard;
  localparam int HIST = plie_pkg::HISTORY_DEPTH_DEF;
  localparam int STEP = plie_pkg::DELAY_STEP_DEF;

  logic [13:0]  word_mem [HIST][6];
  logic [13:0]  parity_mem [HIST];
  logic [13:0]  low_mem [HIST];
  int           line_idx;
  line_result_t expected_q [$];
  int           errors;
  int           lines_in;
  int           lines_out;

  function new();
    for (int n = 0; n < HIST; n++) begin
      for (int k = 0; k < 6; k++) word_mem[n][k] = '0;
      parity_mem[n] = '0;
      low_mem[n]    = '0;
    end
    line_idx  = 0;
    errors    = 0;
    lines_in  = 0;
    lines_out = 0;
  endfunction

  function int slot_back(int delay);
    return (line_idx + HIST - (delay % HIST)) % HIST;
  endfunction

  function logic [15:0] crc_update(logic [15:0] crc, logic [13:0] word);
    logic fb;
    for (int b = 13; b >= 0; b--) begin
      fb  = crc[15] ^ word[b];
      crc = {crc[14:0], 1'b0};
      if (fb) crc = crc ^ plie_pkg::CRC_POLY;
    end
    return crc;
  endfunction

  // Predict the line result for one accepted sample transfer.
  function void note_line(logic [5:0][15:0] smp);
    line_result_t exp_line;
    logic [13:0]  par;
    logic [13:0]  q;
    logic [15:0]  crc;
    par = '0;
    q   = '0;
    for (int k = 0; k < 6; k++) begin
      word_mem[line_idx][k] = smp[k][15:2];
      par = par ^ smp[k][15:2];
      q[13-2*k -: 2] = smp[k][1:0];
    end
    parity_mem[line_idx] = par;
    low_mem[line_idx]    = q;
    crc = '0;
    for (int k = 0; k < 6; k++) begin
      exp_line.words[k] = word_mem[slot_back(k * STEP)][k];
      crc = crc_update(crc, exp_line.words[k]);
    end
    exp_line.parity   = parity_mem[slot_back(6 * STEP)];
    crc               = crc_update(crc, exp_line.parity);
    exp_line.crc      = crc;
    exp_line.low_bits = low_mem[slot_back(7 * STEP)];
    expected_q.push_back(exp_line);
    line_idx = (line_idx + 1) % HIST;
    lines_in++;
  endfunction

  function void compare_field(string name, logic [15:0] exp_val, logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      errors++;
    end
  endfunction

  function void check_line(line_result_t got);
    line_result_t exp_line;
    if (expected_q.size() == 0) begin
      $error("line result with no line pending");
      errors++;
      return;
    end
    exp_line = expected_q.pop_front();
    for (int k = 0; k < 6; k++)
      compare_field($sformatf("word_%0d", k + 1), exp_line.words[k], got.words[k]);
    compare_field("parity_word", exp_line.parity, got.parity);
    compare_field("check_word", exp_line.crc, got.crc);
    compare_field("low_bits_word", exp_line.low_bits, got.low_bits);
    lines_out++;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module pcm_line_interleave_encoder_tb;

  localparam int N_RANDOM    = 1650;
  localparam int N_DIRECTED  = 18;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               sample_valid = 1'b0;
  logic               sample_stall;
  logic signed [15:0] sample_0     = '0;
  logic signed [15:0] sample_1     = '0;
  logic signed [15:0] sample_2     = '0;
  logic signed [15:0] sample_3     = '0;
  logic signed [15:0] sample_4     = '0;
  logic signed [15:0] sample_5     = '0;
  logic               line_valid;
  logic               line_stall   = 1'b0;
  logic [13:0]        word_1;
  logic [13:0]        word_2;
  logic [13:0]        word_3;
  logic [13:0]        word_4;
  logic [13:0]        word_5;
  logic [13:0]        word_6;
  logic [13:0]        parity_word;
  logic [15:0]        check_word;
  logic [13:0]        low_bits_word;

  line_scoreboard sb;
  bit             calm = 1'b1;
  int             stall_left = 0;
  int             cycles = 0;

  pcm_line_interleave_encoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample_0      (sample_0),
    .sample_1      (sample_1),
    .sample_2      (sample_2),
    .sample_3      (sample_3),
    .sample_4      (sample_4),
    .sample_5      (sample_5),
    .line_valid    (line_valid),
    .line_stall    (line_stall),
    .word_1        (word_1),
    .word_2        (word_2),
    .word_3        (word_3),
    .word_4        (word_4),
    .word_5        (word_5),
    .word_6        (word_6),
    .parity_word   (parity_word),
    .check_word    (check_word),
    .low_bits_word (low_bits_word)
  );

  always #5 clk = ~clk;

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [15:0] rand_sample();
    logic [15:0] extremes [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE};
    case ($urandom_range(0, 9))
      6, 7:    return extremes[$urandom_range(0, 5)];
      8, 9:    return 16'($signed($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [5:0][15:0] directed_line(int k);
    logic [5:0][15:0] smp;
    case (k)
      0:  smp = '0;
      1:  smp = {6{16'h7FFF}};
      2:  smp = {6{16'h8000}};
      3:  smp = {6{16'hFFFF}};
      4:  smp = {6{16'h0001}};
      5:  smp = {6{16'hAAAA}};
      6:  smp = {6{16'h5555}};
      7:  smp = {16'h0001, 16'h0003, 16'h0000, 16'h0001, 16'h0002, 16'h0003};
      8:  smp = {{5{16'h8000}}, 16'h7FFF};
      9:  smp = {3{16'h7FFF, 16'h8000}};
      10: smp = {6{16'h0004}};
      11: smp = {6{16'hFFFC}};
      default: begin
        smp = '0;
        smp[k-12] = 16'hFFFF;
      end
    endcase
    return smp;
  endfunction

  task automatic send_line(logic [5:0][15:0] smp);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_0     <= smp[0];
    sample_1     <= smp[1];
    sample_2     <= smp[2];
    sample_3     <= smp[3];
    sample_4     <= smp[4];
    sample_5     <= smp[5];
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    sb.note_line(smp);
  endtask

  // Hold off until every predicted line result has come back.
  task automatic drain_lines();
    sample_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (line_valid && !line_stall) begin
        sb.check_line('{words: {word_6, word_5, word_4, word_3, word_2, word_1},
                        parity: parity_word, crc: check_word, low_bits: low_bits_word});
        stall_left = draw_wait();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      line_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pcm_line_interleave_encoder regression: fail");
      $finish;
    end
  end

  initial begin
    logic [5:0][15:0] smp;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < N_DIRECTED; k++) begin
      if (k == 9) calm = 1'b0;
      send_line(directed_line(k));
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == N_RANDOM / 2) drain_lines();
      for (int k = 0; k < 6; k++) smp[k] = rand_sample();
      send_line(smp);
    end

    drain_lines();
    repeat (12) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d line results never arrived", sb.pending());
      sb.errors++;
    end

    $display("Sent %0d lines and compared %0d line results; the delay stores wrapped %0d times.",
             sb.lines_in, sb.lines_out, sb.lines_in / plie_pkg::HISTORY_DEPTH_DEF);
    if (sb.errors == 0) begin
      $display("pcm_line_interleave_encoder regression: pass");
    end else begin
      $display("pcm_line_interleave_encoder regression: fail");
    end
    $finish;
  end

endmodule
